### rtl/core/mscp_pkg.sv
package mscp_pkg;

	localparam int MAX_COLUMNS_DEF = 16;

	localparam int HEIGHT_W = 32;
	localparam int LEN_W    = 16;
	localparam int ITEM_H_W = 20;
	localparam int INDEX_W  = 20;
	localparam int COL_W    = 4;
	localparam int X_W      = 17;
	localparam int COUNT_W  = 5;

	localparam logic [ITEM_H_W-1:0] FALLBACK_HEIGHT = ITEM_H_W'(1600);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX      = '1;
	localparam logic [INDEX_W-1:0]  INDEX_MAX       = '1;
	localparam logic [X_W-1:0]      X_MAX           = '1;

	localparam int DIV_STEPS  = LEN_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 112;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMN_COUNT   = 3'd0,
		REG_COLUMN_GAP     = 3'd1,
		REG_ROW_GAP        = 3'd2,
		REG_VIEWPORT_WIDTH = 3'd3,
		REG_INSET_TOP      = 3'd4,
		REG_INSET_LEFT     = 3'd5,
		REG_INSET_RIGHT    = 3'd6
	} reg_idx_t;

	// running minimum handed from cell to cell
	typedef struct packed {
		logic                valid;
		logic [HEIGHT_W-1:0] val;
	} tok_t;

	// broadcast to every cell
	typedef struct packed {
		logic                load_all;
		logic [HEIGHT_W-1:0] load_val;
		logic                wr_en;
		logic [HEIGHT_W-1:0] wr_val;
	} cell_ctrl_t;

endpackage

### rtl/core/mscp_cell.sv
module mscp_cell #(
	parameter int MAX_COLUMNS = mscp_pkg::MAX_COLUMNS_DEF,
	parameter int CELL_IDX    = 0,
	parameter int CW          = $clog2(MAX_COLUMNS + 1),
	parameter int IW          = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mscp_pkg::cell_ctrl_t ctrl,
	input  logic [IW-1:0]        wr_idx,
	input  logic [CW-1:0]        cols,
	input  mscp_pkg::tok_t       tok_in,
	input  logic [IW-1:0]        idx_in,
	output mscp_pkg::tok_t       tok_out,
	output logic [IW-1:0]        idx_out
);
	import mscp_pkg::*;

	localparam bit IS_HEAD = (CELL_IDX == 0);

	logic [HEIGHT_W-1:0] height_q;
	logic                tok_valid_q;
	logic [HEIGHT_W-1:0] tok_val_q;
	logic [IW-1:0]       idx_q;
	logic                active;
	logic                take;

	assign active = (32'(CELL_IDX) < 32'(cols));
	// strict less keeps the lower column on a tie; the head cell always seeds the minimum
	assign take   = IS_HEAD || (active && (height_q < tok_in.val));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q    <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
			if (ctrl.load_all) begin
				height_q <= ctrl.load_val;
			end else if (ctrl.wr_en && (wr_idx == IW'(CELL_IDX))) begin
				height_q <= ctrl.wr_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_val_q <= height_q;
			idx_q     <= IW'(CELL_IDX);
		end else begin
			tok_val_q <= tok_in.val;
			idx_q     <= idx_in;
		end
	end

	assign tok_out.valid = tok_valid_q;
	assign tok_out.val   = tok_val_q;
	assign idx_out       = idx_q;

endmodule

### rtl/core/mscp_divider.sv
module mscp_divider #(
	parameter int CW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mscp_pkg::LEN_W-1:0] dividend,
	input  logic [CW-1:0]              divisor,
	output logic                       done,
	output logic [mscp_pkg::LEN_W-1:0] quotient
);
	import mscp_pkg::*;

	logic                 running_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CW-1:0]        rem_q;
	logic [LEN_W-1:0]     quo_q;
	logic [CW-1:0]        divisor_q;
	logic [CW:0]          rem_sh;
	logic                 ge;
	logic [CW-1:0]        rem_nxt;

	// restoring division, one quotient bit a cycle
	assign rem_sh  = {rem_q, quo_q[LEN_W-1]};
	assign ge      = (rem_sh >= {1'b0, divisor_q});
	assign rem_nxt = ge ? CW'(rem_sh - {1'b0, divisor_q}) : rem_sh[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (running_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[LEN_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/masonry_shortest_column_placer.sv
// channel | dir | handshake            | payload
// s       | in  | s_tvalid / s_tready  | s_tdata item_height, s_tuser first_item, height_given
// m       | out | m_tvalid / m_tready  | m_tdata placement, m_tuser overflow
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// an item goes through accept, launch, a scan while the running minimum walks the column
// chain cell by cell, and write-back
// a first item also passes prep and the 16-step column width divider before launch
// arst_n clears the control and config registers to their reset values and all column heights to zero
// the output register holds a result until m_tready; a new item is taken meanwhile,
// but write-back waits for a free output register
module masonry_shortest_column_placer #(
	parameter int MAX_COLUMNS = mscp_pkg::MAX_COLUMNS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mscp_pkg::S_TDATA_W-1:0]    s_tdata,   // item_height[19:0], zero pad
	input  logic [mscp_pkg::S_TUSER_W-1:0]    s_tuser,   // first_item[0], height_given[1]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// item_index[19:0], column_chosen[23:20], pos_x[40:24], pos_y[72:41],
	// item_width[88:73], placed_height[108:89], zero pad
	output logic [mscp_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tuser,   // overflow[0]
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mscp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mscp_pkg::LEN_W-1:0]        cfg_data
);
	import mscp_pkg::*;

	localparam int CW   = $clog2(MAX_COLUMNS + 1);
	localparam int IW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int AW   = LEN_W + CW + 2;
	localparam int XP_W = LEN_W + 1 + IW;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PREP   = 6'b000010,
		ST_DIV    = 6'b000100,
		ST_LAUNCH = 6'b001000,
		ST_SCAN   = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0] column_count_q;
	logic [LEN_W-1:0]   column_gap_q;
	logic [LEN_W-1:0]   row_gap_q;
	logic [LEN_W-1:0]   viewport_width_q;
	logic [LEN_W-1:0]   inset_top_q;
	logic [LEN_W-1:0]   inset_left_q;
	logic [LEN_W-1:0]   inset_right_q;

	logic [INDEX_W-1:0]  next_index_q;
	logic [LEN_W-1:0]    width_q;
	logic [CW-1:0]       cols_q;
	logic [ITEM_H_W-1:0] h_q;
	logic [IW-1:0]       best_q;
	logic [HEIGHT_W-1:0] y_q;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic                 out_ovf_q;

	logic [CW-1:0]       cols_now;
	logic                in_acc;
	logic                fin_go;
	cell_ctrl_t          ctrl;

	tok_t                tok   [MAX_COLUMNS+1];
	logic [IW-1:0]       idx_c [MAX_COLUMNS+1];

	logic [CW-1:0]          cols_m1;
	logic [LEN_W+CW-1:0]    gap_prod;
	logic [AW-1:0]          avail;
	logic [LEN_W-1:0]       dividend;
	logic                   div_start;
	logic                   div_done;
	logic [LEN_W-1:0]       div_quo;

	logic [HEIGHT_W+1:0]    sum;
	logic                   ovf;
	logic [HEIGHT_W-1:0]    new_h;
	logic [XP_W-1:0]        x_prod;
	logic [XP_W:0]          xs;
	logic [X_W-1:0]         pos_x;
	logic [COL_W-1:0]       col_out;

	assign cols_now  = (32'(column_count_q) > 32'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS)
	                                                             : CW'(column_count_q);
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready && (cols_now != '0);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q   <= COUNT_W'(2);
			column_gap_q     <= LEN_W'(128);
			row_gap_q        <= LEN_W'(128);
			viewport_width_q <= LEN_W'(6240);
			inset_top_q      <= '0;
			inset_left_q     <= '0;
			inset_right_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COLUMN_COUNT:   column_count_q   <= cfg_data[COUNT_W-1:0];
				REG_COLUMN_GAP:     column_gap_q     <= cfg_data;
				REG_ROW_GAP:        row_gap_q        <= cfg_data;
				REG_VIEWPORT_WIDTH: viewport_width_q <= cfg_data;
				REG_INSET_TOP:      inset_top_q      <= cfg_data;
				REG_INSET_LEFT:     inset_left_q     <= cfg_data;
				REG_INSET_RIGHT:    inset_right_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// available width; negative or zero gives a zero column width
	assign cols_m1  = cols_q - 1'b1;
	assign gap_prod = (LEN_W+CW)'(cols_m1) * (LEN_W+CW)'(column_gap_q);
	assign avail    = AW'(viewport_width_q) - AW'(inset_left_q) - AW'(inset_right_q)
	                - AW'(gap_prod);
	assign dividend = (!avail[AW-1] && (avail != '0)) ? avail[LEN_W-1:0] : '0;
	assign div_start = (state_q == ST_PREP);

	mscp_divider #(.CW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (cols_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// column chain
	assign tok[0].valid = (state_q == ST_LAUNCH);
	assign tok[0].val   = '0;
	assign idx_c[0]     = '0;

	assign ctrl.load_all = in_acc && s_tuser[0];
	assign ctrl.load_val = HEIGHT_W'(inset_top_q);
	assign ctrl.wr_en    = fin_go;
	assign ctrl.wr_val   = new_h;

	for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
		mscp_cell #(
			.MAX_COLUMNS (MAX_COLUMNS),
			.CELL_IDX    (g),
			.CW          (CW),
			.IW          (IW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.wr_idx  (best_q),
			.cols    (cols_q),
			.tok_in  (tok[g]),
			.idx_in  (idx_c[g]),
			.tok_out (tok[g+1]),
			.idx_out (idx_c[g+1])
		);
	end

	// placement arithmetic on the chosen column
	assign sum     = (HEIGHT_W+2)'(y_q) + (HEIGHT_W+2)'(h_q) + (HEIGHT_W+2)'(row_gap_q);
	assign ovf     = (sum > (HEIGHT_W+2)'(HEIGHT_MAX));
	assign new_h   = ovf ? HEIGHT_MAX : sum[HEIGHT_W-1:0];
	assign x_prod  = XP_W'(best_q) * XP_W'((LEN_W+1)'(width_q) + (LEN_W+1)'(column_gap_q));
	assign xs      = (XP_W+1)'(inset_left_q) + (XP_W+1)'(x_prod);
	assign pos_x   = (xs > (XP_W+1)'(X_MAX)) ? X_MAX : X_W'(xs);
	assign col_out = COL_W'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			next_index_q <= '0;
			width_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser[0]) begin
							next_index_q <= '0;
							state_q      <= ST_PREP;
						end else begin
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						width_q <= div_quo;
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (tok[MAX_COLUMNS].valid) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						if (next_index_q != INDEX_MAX) begin
							next_index_q <= next_index_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			h_q    <= s_tuser[1] ? s_tdata[ITEM_H_W-1:0] : FALLBACK_HEIGHT;
			cols_q <= cols_now;
		end
		if ((state_q == ST_SCAN) && tok[MAX_COLUMNS].valid) begin
			best_q <= idx_c[MAX_COLUMNS];
			y_q    <= tok[MAX_COLUMNS].val;
		end
		if (fin_go) begin
			out_data_q <= M_TDATA_W'({h_q, width_q, y_q, pos_x, col_out, next_index_q});
			out_ovf_q  <= ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ovf_q;

endmodule

### rtl/core/mscp_checker.sv
module mscp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mscp_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	// a stalled transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output payload changed while stalled");

	// a result appears only from write-back, when no item is taken
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while input was ready");

	// saturation only happens with pos_y near the top of its range
	a_ovf_y: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (&m_tdata[72:62]))
		else $error("overflow flagged with small pos_y");

	// an overflow needs a column that already holds something
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[72:41] != 32'd0)
		else $error("overflow flagged with zero pos_y");

endmodule

bind masonry_shortest_column_placer mscp_checker u_mscp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
